FILE: src/svlf_pkg.sv
// Shared types, constants and arithmetic helpers for the stereo VU bar LED framer.
// Used by svlf_ctrl, svlf_datapath and stereo_vu_bar_led_framer_unit; no dependencies.
`default_nettype none

package svlf_pkg;

    // Level scale and LED frame constants.
    localparam logic [14:0] LVL_KNEE     = 15'h2000;
    localparam logic [14:0] LVL_FULL     = 15'h7FFF;
    localparam logic [7:0]  RED_STEP     = 8'd36;
    localparam logic [7:0]  BYTE_MAX     = 8'd255;
    localparam logic [7:0]  LED_HEADER   = 8'hE0 | 8'd15;
    localparam logic [7:0]  BRIGHT_RESET = 8'd255;
    localparam int          NUM_LEDS     = 8;
    localparam int          LED_W        = $clog2(NUM_LEDS);

    // Frame sequence of one update: start, right LEDs 7..0, left LEDs 0..7, end.
    localparam int              FRAME_COUNT = 2 * NUM_LEDS + 2;
    localparam int              FRAME_W     = $clog2(FRAME_COUNT);
    localparam logic [FRAME_W-1:0] FRAME_START      = FRAME_W'(0);
    localparam logic [FRAME_W-1:0] FRAME_RIGHT_BASE = FRAME_W'(NUM_LEDS);
    localparam logic [FRAME_W-1:0] FRAME_LEFT_FIRST = FRAME_W'(NUM_LEDS + 1);
    localparam logic [FRAME_W-1:0] FRAME_END        = FRAME_W'(FRAME_COUNT - 1);

    localparam logic [2:0] LED_FRAME_BYTES = 3'd4;
    localparam logic [2:0] END_FRAME_BYTES = 3'd5;

    // One input request: both channel peak levels.
    typedef struct packed {
        logic [14:0] level_left;
        logic [14:0] level_right;
    } in_item_t;

    // One result request: a frame of the LED stream.
    typedef struct packed {
        logic [39:0] frame_data;
        logic [2:0]  frame_bytes;
        logic        last_frame;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        logic               bar_mul;
        logic               bar_div;
        logic               color_mul;
        logic               emit;
        logic [FRAME_W-1:0] frame_idx;
    } svlf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } svlf_status_t;

    // Number of dark LEDs at the top of the bar: the smallest d below 7 with
    // level << 2d at or above the knee, and 7 when no such d exists.
    function automatic logic [2:0] dark_count(input logic [14:0] lvl);
        logic [2:0] dc;
        dc = 3'd7;
        for (int d = NUM_LEDS - 2; d >= 0; d--) begin
            if (lvl >= 15'(LVL_KNEE >> (2 * d))) begin
                dc = 3'(d);
            end
        end
        return dc;
    endfunction

    // Exact x / 32767 for x below 256 * 32767, using x = q0 * 32767 + lo + q0.
    function automatic logic [7:0] div_full(input logic [22:0] x);
        logic [7:0]  q0;
        logic [15:0] r;
        logic [8:0]  q;
        q0 = x[22:15];
        r  = 16'(x[14:0]) + 16'(q0);
        q  = 9'(q0) + ((r >= 16'(LVL_FULL)) ? 9'd1 : 9'd0);
        return q[7:0];
    endfunction

    // Exact x / 255 for x up to 255 * 255, using x = q0 * 255 + lo + q0.
    function automatic logic [7:0] div_byte(input logic [15:0] x);
        logic [7:0] q0;
        logic [8:0] r;
        logic [8:0] q;
        q0 = x[15:8];
        r  = 9'(x[7:0]) + 9'(q0);
        q  = 9'(q0) + ((r >= 9'(BYTE_MAX)) ? 9'd1 : 9'd0);
        return q[7:0];
    endfunction

    // Red weight of an LED position; the green weight is its complement to 255.
    function automatic logic [7:0] red_coef(input logic [LED_W-1:0] idx);
        return 8'(8'(idx) * RED_STEP);
    endfunction

endpackage

`default_nettype wire

FILE: src/svlf_ctrl.sv
// Sequencer of the stereo VU bar LED framer: walks one update through its frames.
// Depends on svlf_pkg for the command and status structs and frame constants.
`default_nettype none

module svlf_ctrl
    import svlf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire svlf_status_t status,
    output svlf_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BMUL  = 5'b00010,
        ST_BDIV  = 5'b00100,
        ST_CMUL  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        frame_next    = frame_reg;
        cmd           = '0;
        cmd.frame_idx = frame_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    frame_next = FRAME_START;
                    state_next = ST_BMUL;
                end
            end
            ST_BMUL: begin
                cmd.bar_mul = 1'b1;
                state_next  = ST_BDIV;
            end
            ST_BDIV: begin
                cmd.bar_div = 1'b1;
                state_next  = ST_CMUL;
            end
            ST_CMUL: begin
                cmd.color_mul = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (frame_reg == FRAME_END) begin
                        state_next = ST_IDLE;
                    end else begin
                        frame_next = frame_reg + FRAME_W'(1);
                        state_next = ST_CMUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and frame counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            frame_reg <= FRAME_START;
        end else begin
            state_reg <= state_next;
            frame_reg <= frame_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/svlf_datapath.sv
// Datapath of the stereo VU bar LED framer: bar values, color scaling, output register.
// Depends on svlf_pkg for payload types, commands and arithmetic helpers.
`default_nettype none

module svlf_datapath
    import svlf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [7:0] cfg_data,
    input  wire in_item_t  s_data,
    input  wire svlf_cmd_t cmd,
    output svlf_status_t   status,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic [7:0]       bright_reg;
    logic [14:0]      leff_l_reg, leff_r_reg;
    logic [2:0]       lit_l_reg, lit_r_reg;
    logic [22:0]      prod_l_reg, prod_r_reg;
    logic [7:0]       part_l_reg, part_r_reg;
    logic [15:0]      green_prod_reg, red_prod_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic [2:0]       dark_l, dark_r;
    logic             is_right;
    logic [FRAME_W-1:0] right_off, left_off;
    logic [LED_W-1:0] led_idx;
    logic [2:0]       lit_sel;
    logic [7:0]       part_sel;
    logic [7:0]       bar_val;
    logic [7:0]       red_w, green_w;
    out_item_t        frame;

    assign cfg_ready       = 1'b1;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

    // Brightness register, written from the configuration channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= BRIGHT_RESET;
        end else if (cfg_valid) begin
            bright_reg <= cfg_data;
        end
    end

    // The lit LED is the first one below the dark run; its level is shifted
    // up by two bits per dark LED.
    assign dark_l = dark_count(s_data.level_left);
    assign dark_r = dark_count(s_data.level_right);

    // Capture, bar product and bar division stages of one update.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            leff_l_reg <= s_data.level_left << {dark_l, 1'b0};
            leff_r_reg <= s_data.level_right << {dark_r, 1'b0};
            lit_l_reg  <= 3'(NUM_LEDS - 1) - dark_l;
            lit_r_reg  <= 3'(NUM_LEDS - 1) - dark_r;
        end
        if (cmd.bar_mul) begin
            prod_l_reg <= 23'(bright_reg) * 23'(leff_l_reg);
            prod_r_reg <= 23'(bright_reg) * 23'(leff_r_reg);
        end
        if (cmd.bar_div) begin
            part_l_reg <= div_full(prod_l_reg);
            part_r_reg <= div_full(prod_r_reg);
        end
    end

    // Channel and LED position of the current frame: right LEDs run downward
    // from 7, left LEDs upward from 0.
    assign is_right  = (cmd.frame_idx != FRAME_START) && (cmd.frame_idx <= FRAME_RIGHT_BASE);
    assign right_off = FRAME_RIGHT_BASE - cmd.frame_idx;
    assign left_off  = cmd.frame_idx - FRAME_LEFT_FIRST;
    assign led_idx   = is_right ? right_off[LED_W-1:0] : left_off[LED_W-1:0];
    assign lit_sel   = is_right ? lit_r_reg : lit_l_reg;
    assign part_sel  = is_right ? part_r_reg : part_l_reg;

    // Bar value: dark above the lit LED, partial at it, full below it.
    always_comb begin
        if (3'(led_idx) > lit_sel) begin
            bar_val = 8'd0;
        end else if (3'(led_idx) == lit_sel) begin
            bar_val = part_sel;
        end else begin
            bar_val = bright_reg;
        end
    end

    assign red_w   = red_coef(led_idx);
    assign green_w = BYTE_MAX - red_w;

    // Color products of the current LED.
    always_ff @(posedge aclk) begin
        if (cmd.color_mul) begin
            green_prod_reg <= 16'(green_w) * 16'(bar_val);
            red_prod_reg   <= 16'(red_w) * 16'(bar_val);
        end
    end

    // Frame assembly: start and end frames are all zero bytes.
    always_comb begin
        frame.frame_data  = {8'd0, LED_HEADER, 8'd0, div_byte(green_prod_reg),
                             div_byte(red_prod_reg)};
        frame.frame_bytes = LED_FRAME_BYTES;
        frame.last_frame  = 1'b0;
        if (cmd.frame_idx == FRAME_START) begin
            frame.frame_data = 40'd0;
        end else if (cmd.frame_idx == FRAME_END) begin
            frame.frame_data  = 40'd0;
            frame.frame_bytes = END_FRAME_BYTES;
            frame.last_frame  = 1'b1;
        end
    end

    // Output register of the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= frame;
        end
    end

endmodule

`default_nettype wire

FILE: src/stereo_vu_bar_led_framer_unit.sv
// Each accepted level request yields 18 frame requests: a start frame of
// four zero bytes, eight right-channel LED frames (LED 7 down to 0), eight
// left-channel LED frames (LED 0 up to 7), and a five-byte zero end frame
// flagged by last_frame. Each channel's level lights the bar on a 4x log
// scale scaled by the bar_brightness register (reset 255), which may be
// written while the block is idle. One update runs the setup steps
// capture, bar product and bar division, then for each frame a color
// product and an output load; these product and load steps set the rate,
// and an output load waits while the sink has not taken the last frame.
// The next level request is taken once the end frame sits in the output
// register.
// Top level: joins svlf_ctrl and svlf_datapath; depends on svlf_pkg.
`default_nettype none

module stereo_vu_bar_led_framer_unit
    import svlf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    svlf_cmd_t    cmd;
    svlf_status_t status;

    // Frame sequencer.
    svlf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Bar and frame arithmetic with the output register.
    svlf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
